[src/vca_pkg.sv]
// Package for the voice channel allocator: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package vca_pkg;
    localparam int NUM_CHANNELS = 22;
    localparam int NUM_SLOTS    = 64;
    localparam int CH_W         = 5;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int SLOT_W       = 6;
    localparam int RATE_W       = 17;
    localparam int SER_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic [SER_W-1:0]  SERIAL_NONE     = 32'hFFFF_FFFF;
    localparam logic [SLOT_W-1:0] FIXED_RATE_SLOT = 6'hD;
    localparam logic [RATE_W-1:0] FIXED_RATE      = RATE_W'(22050 + 5512);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOADED = 2'd1;

    typedef enum logic [1:0] {
        OP_ONESHOT  = 2'd0,
        OP_LOOP     = 2'd1,
        OP_STOP     = 2'd2,
        OP_STOP_ALL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_START  = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic pick;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_pick;
        logic found;
        logic scan_last;
    } t_status;
endpackage

[src/vca_ctrl.sv]
// Sequencer for the voice channel allocator: accept, read, execute,
// pick, scan, finish, deliver. Depends on vca_pkg.
`timescale 1ns / 1ps
module vca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  vca_pkg::t_status i_status,
    output vca_pkg::t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_PICK, S_SCAN, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.read      = (r_state == S_READ);
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.pick      = (r_state == S_PICK);
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.finish    = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_READ;
                S_READ: r_state <= S_EXEC;
                S_EXEC: r_state <= i_status.need_pick ? S_PICK : S_OUT;
                S_PICK: r_state <= i_status.found ? S_OUT : S_SCAN;
                S_SCAN: if (i_status.scan_last) r_state <= S_FIN;
                S_FIN:  r_state <= S_OUT;
                S_OUT:  if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/vca_dp.sv]
// Datapath for the voice channel allocator: config registers, channel
// table, slot loop memory, oldest-start scan and result registers. Depends on vca_pkg.
`timescale 1ns / 1ps
module vca_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vca_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vca_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [1:0]                           i_opcode,
    input  logic [vca_pkg::SLOT_W-1:0]           i_slot,
    input  logic [vca_pkg::RATE_W-1:0]           i_rate,
    input  logic [vca_pkg::NUM_CHANNELS-1:0]     i_playing,
    input  vca_pkg::t_cmd                        i_cmd,
    output vca_pkg::t_status                     o_status,
    output logic [1:0]                           o_action,
    output logic [vca_pkg::CH_W-1:0]             o_channel,
    output logic [vca_pkg::RATE_W-1:0]           o_start_rate,
    output logic                                 o_start_looping,
    output logic [vca_pkg::NUM_CHANNELS-1:0]     o_clear_mask
);
    localparam int NC = vca_pkg::NUM_CHANNELS;
    localparam int MW = vca_pkg::CH_W + vca_pkg::RATE_W;

    logic                          r_enable;
    logic [vca_pkg::NUM_SLOTS-1:0] r_loaded;

    logic [1:0]                    r_op;
    logic [vca_pkg::SLOT_W-1:0]    r_slot;
    logic [vca_pkg::RATE_W-1:0]    r_rate;
    logic [NC-1:0]                 r_play;

    logic [MW-1:0]                 r_mem [vca_pkg::NUM_SLOTS];
    logic [MW-1:0]                 r_mem_q;
    logic [vca_pkg::NUM_SLOTS-1:0] r_loop;

    logic [NC-1:0]                 r_own_v;
    logic [vca_pkg::SLOT_W-1:0]    r_own [NC];
    logic [NC-1:0]                 r_pin;
    logic [vca_pkg::SER_W-1:0]     r_ser [NC];
    logic [vca_pkg::SER_W-1:0]     r_cnt;

    logic [vca_pkg::CH_IDX_W-1:0]  r_idx;
    logic                          r_best_v;
    logic [vca_pkg::SER_W-1:0]     r_best_ser;
    logic [vca_pkg::CH_IDX_W-1:0]  r_best_ch;

    logic [1:0]                    r_action;
    logic [vca_pkg::CH_W-1:0]      r_channel;
    logic [vca_pkg::RATE_W-1:0]    r_orate;
    logic                          r_olooping;
    logic [NC-1:0]                 r_clear;

    logic                          n_ign;
    logic                          n_is_loop;
    logic [vca_pkg::CH_W-1:0]      n_pin_ch;
    logic [vca_pkg::RATE_W-1:0]    n_pin_rate;
    logic [vca_pkg::RATE_W-1:0]    n_rate_eff;
    logic [NC-1:0]                 n_free;
    logic                          n_found;
    logic [vca_pkg::CH_IDX_W-1:0]  n_first;
    logic                          n_cand;
    logic                          n_commit;
    logic [vca_pkg::CH_IDX_W-1:0]  n_commit_ch;
    logic [vca_pkg::SER_W-1:0]     n_cnt;
    logic [NC-1:0]                 n_stop_hit;

    assign n_ign = !r_enable
        || ((r_op == vca_pkg::OP_ONESHOT || r_op == vca_pkg::OP_LOOP) && !r_loaded[r_slot]);
    assign n_is_loop  = (r_op == vca_pkg::OP_LOOP);
    assign n_pin_ch   = r_mem_q[vca_pkg::CH_W-1:0];
    assign n_pin_rate = r_mem_q[MW-1:vca_pkg::CH_W];
    assign n_rate_eff = (r_op == vca_pkg::OP_ONESHOT && r_slot == vca_pkg::FIXED_RATE_SLOT)
                        ? vca_pkg::FIXED_RATE : r_rate;
    assign n_cnt = r_cnt + 1'b1;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_free[c]     = !r_own_v[c] || (!r_pin[c] && !r_play[c]);
            n_stop_hit[c] = r_own_v[c] && (r_own[c] == r_slot);
        end
        n_found = |n_free;
        n_first = '0;
        for (int c = NC - 1; c >= 0; c--) begin
            if (n_free[c]) n_first = vca_pkg::CH_IDX_W'(c);
        end
    end

    assign n_cand = !r_pin[r_idx] && (r_ser[r_idx] < r_best_ser);
    assign n_commit = (i_cmd.pick && n_found) || (i_cmd.finish && r_best_v);
    assign n_commit_ch = i_cmd.pick ? n_first : r_best_ch;

    assign o_status.need_pick = !n_ign
        && (r_op == vca_pkg::OP_ONESHOT || (n_is_loop && !r_loop[r_slot]));
    assign o_status.found     = n_found;
    assign o_status.scan_last = (r_idx == vca_pkg::CH_IDX_W'(NC - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_loaded <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == vca_pkg::REG_ENABLE) r_enable <= i_cfg_data[0];
            if (i_cfg_index == vca_pkg::REG_LOADED) r_loaded <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_slot <= i_slot;
            r_rate <= i_rate;
            r_play <= i_playing;
        end
        if (i_cmd.read) r_mem_q <= r_mem[r_slot];
        if (i_cmd.exec && !n_ign && n_is_loop && r_loop[r_slot]
            && r_rate != '0 && n_pin_rate != r_rate) begin
            r_mem[r_slot] <= {r_rate, n_pin_ch};
        end else if (n_commit && n_is_loop) begin
            r_mem[r_slot] <= {r_rate, vca_pkg::CH_W'(n_commit_ch)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_v <= '0;
            r_pin   <= '0;
            r_loop  <= '0;
            r_cnt   <= '0;
            for (int c = 0; c < NC; c++) r_ser[c] <= '0;
        end else begin
            if (i_cmd.exec && !n_ign) begin
                unique case (r_op)
                    vca_pkg::OP_STOP_ALL: begin
                        r_own_v <= '0;
                        r_pin   <= '0;
                        r_loop  <= '0;
                    end
                    vca_pkg::OP_STOP: begin
                        r_own_v <= r_own_v & ~n_stop_hit;
                        r_loop[r_slot] <= 1'b0;
                    end
                    vca_pkg::OP_ONESHOT: begin
                        if (r_loop[r_slot]) begin
                            r_own_v[n_pin_ch] <= 1'b0;
                            r_loop[r_slot]    <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (n_commit) begin
                r_own_v[n_commit_ch] <= 1'b1;
                r_pin[n_commit_ch]   <= n_is_loop;
                r_ser[n_commit_ch]   <= n_cnt;
                r_cnt                <= n_cnt;
                if (n_is_loop) r_loop[r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_commit) r_own[n_commit_ch] <= r_slot;
        if (i_cmd.pick) begin
            r_idx      <= '0;
            r_best_v   <= 1'b0;
            r_best_ser <= vca_pkg::SERIAL_NONE;
            r_best_ch  <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (n_cand) begin
                r_best_v   <= 1'b1;
                r_best_ser <= r_ser[r_idx];
                r_best_ch  <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_action   <= vca_pkg::ACT_NONE;
            r_channel  <= '0;
            r_orate    <= '0;
            r_olooping <= 1'b0;
            r_clear    <= '0;
            if (!n_ign) begin
                unique case (r_op)
                    vca_pkg::OP_STOP_ALL: begin
                        r_action <= vca_pkg::ACT_CLEAR;
                        r_clear  <= '1;
                    end
                    vca_pkg::OP_STOP: begin
                        r_action <= vca_pkg::ACT_CLEAR;
                        r_clear  <= n_stop_hit;
                    end
                    vca_pkg::OP_LOOP: begin
                        if (r_loop[r_slot] && r_rate != '0 && n_pin_rate != r_rate) begin
                            r_action  <= vca_pkg::ACT_UPDATE;
                            r_channel <= n_pin_ch;
                            r_orate   <= r_rate;
                        end
                    end
                    vca_pkg::OP_ONESHOT: begin
                        if (r_loop[r_slot]) r_clear[n_pin_ch] <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end else if (n_commit) begin
            r_action   <= vca_pkg::ACT_START;
            r_channel  <= vca_pkg::CH_W'(n_commit_ch);
            r_orate    <= n_rate_eff;
            r_olooping <= n_is_loop;
        end else if (i_cmd.finish) begin
            r_action <= (!n_is_loop && r_clear != '0) ? vca_pkg::ACT_CLEAR
                                                       : vca_pkg::ACT_NONE;
        end
    end

    assign o_action        = r_action;
    assign o_channel       = r_channel;
    assign o_start_rate    = r_orate;
    assign o_start_looping = r_olooping;
    assign o_clear_mask    = r_clear;
endmodule

[src/voice_channel_allocator_top.sv]
// Top level of the voice channel allocator: stream ports, config port,
// controller and datapath. Depends on vca_pkg, vca_ctrl, vca_dp.
//
// Usage: one request enters on the s-side stream (tuser = opcode); exactly
// one result leaves on the m-side stream (tuser = action). One request is
// handled at a time. From acceptance a request passes S_READ and S_EXEC;
// stops, rate updates and ignored requests then give their result, a free
// channel is taken in S_PICK, and the oldest channel is stolen via S_PICK,
// S_SCAN and S_FIN; the steal search visits one channel per cycle. The slot
// memory is read in S_READ first. The next request is accepted the cycle
// after the result is taken. Config writes (index 0 enable, 1 loaded mask)
// are always accepted and take effect on the next cycle; write them only
// while no request is in flight. Reset is synchronous: all channels free,
// no slot looping, serial counter zero, block disabled. A stalled receiver
// holds the result and the s-side stays not ready.
`timescale 1ns / 1ps
module voice_channel_allocator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [47:0]                      i_s_tdata,  // slot, rate, playing_mask
    input  logic [1:0]                       i_s_tuser,  // opcode
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [47:0]                      o_m_tdata,  // channel, start_rate,
                                                         // start_looping, clear_mask
    output logic [1:0]                       o_m_tuser,  // action
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vca_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vca_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    vca_pkg::t_cmd                    w_cmd;
    vca_pkg::t_status                 w_status;
    logic [vca_pkg::CH_W-1:0]         w_channel;
    logic [vca_pkg::RATE_W-1:0]       w_rate;
    logic                             w_looping;
    logic [vca_pkg::NUM_CHANNELS-1:0] w_clear;

    assign o_cfg_ready = 1'b1;

    vca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    vca_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_s_tuser),
        .i_slot          (i_s_tdata[5:0]),
        .i_rate          (i_s_tdata[22:6]),
        .i_playing       (i_s_tdata[44:23]),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_action        (o_m_tuser),
        .o_channel       (w_channel),
        .o_start_rate    (w_rate),
        .o_start_looping (w_looping),
        .o_clear_mask    (w_clear)
    );

    assign o_m_tdata = {3'b000, w_clear, w_looping, w_rate, w_channel};

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("request accepted while a result is pending");
    a_start_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == vca_pkg::ACT_START)
        |-> (w_channel < vca_pkg::CH_W'(vca_pkg::NUM_CHANNELS)))
        else $error("start on a channel that does not exist");
    a_loop_only_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != vca_pkg::ACT_START) |-> !w_looping)
        else $error("looping flag set without a start");
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("result valid too early");
`endif
endmodule

[verif/voice_channel_allocator_top_tb.sv]
// Self-checking testbench for voice_channel_allocator_top: stream requests with
// random stalls, an in-bench predictor of channel choice, stealing and loops.
// Depends on vca_pkg and the RTL of voice_channel_allocator_top.
`timescale 1ns / 1ps
module voice_channel_allocator_top_tb;
    typedef struct packed {
        vca_pkg::t_action           action;
        logic [vca_pkg::CH_W-1:0]   channel;
        logic [vca_pkg::RATE_W-1:0] start_rate;
        logic                       start_looping;
        logic [21:0]                clear_mask;
    } t_alloc;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [vca_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [vca_pkg::CFG_DATA_W-1:0] i_cfg_data;

    voice_channel_allocator_top i_dut (.*);

    // predictor state
    logic                       blk_enable;
    logic [63:0]                clip_loaded;
    logic                       own_v    [vca_pkg::NUM_CHANNELS];
    logic [vca_pkg::SLOT_W-1:0] own_slot [vca_pkg::NUM_CHANNELS];
    logic [vca_pkg::SER_W-1:0]  serial   [vca_pkg::NUM_CHANNELS];
    logic [vca_pkg::SER_W-1:0]  serial_cnt;
    logic                       pin_v    [vca_pkg::NUM_SLOTS];
    logic [vca_pkg::CH_W-1:0]   pin_ch   [vca_pkg::NUM_SLOTS];
    logic                       looping  [vca_pkg::NUM_SLOTS];
    logic                       lrate_v  [vca_pkg::NUM_SLOTS];
    logic [vca_pkg::RATE_W-1:0] lrate    [vca_pkg::NUM_SLOTS];

    t_alloc alloc_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL voice_channel_allocator_top");
        $finish;
    end

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic void release_loop(int s);
        pin_v[s]   = 1'b0;
        looping[s] = 1'b0;
        lrate_v[s] = 1'b0;
    endfunction

    function automatic int pick_channel(logic [21:0] playing);
        int best;
        logic [vca_pkg::SER_W-1:0] best_ser;
        best = -1;
        best_ser = vca_pkg::SERIAL_NONE;
        for (int c = 0; c < vca_pkg::NUM_CHANNELS; c++) begin
            if (!own_v[c])
                return c;
            if (looping[own_slot[c]] && pin_v[own_slot[c]] && pin_ch[own_slot[c]] == c)
                continue;
            if (!playing[c])
                return c;
            if (serial[c] < best_ser) begin
                best_ser = serial[c];
                best = c;
            end
        end
        return best;
    endfunction

    function automatic void start_on(int c, int s);
        own_v[c] = 1'b1;
        own_slot[c] = vca_pkg::SLOT_W'(s);
        serial_cnt = serial_cnt + 1'b1;
        serial[c] = serial_cnt;
    endfunction

    function automatic t_alloc predict_alloc(vca_pkg::t_op op, int s,
                                             logic [vca_pkg::RATE_W-1:0] rate,
                                             logic [21:0] playing);
        t_alloc r;
        int c;
        r = '0;
        r.action = vca_pkg::ACT_NONE;
        if (!blk_enable) begin
        end else if (op == vca_pkg::OP_STOP_ALL) begin
            for (int i = 0; i < vca_pkg::NUM_CHANNELS; i++) own_v[i] = 1'b0;
            for (int i = 0; i < vca_pkg::NUM_SLOTS; i++) release_loop(i);
            r.clear_mask = '1;
            r.action = vca_pkg::ACT_CLEAR;
        end else if (op == vca_pkg::OP_STOP) begin
            for (int i = 0; i < vca_pkg::NUM_CHANNELS; i++)
                if (own_v[i] && own_slot[i] == s) begin
                    r.clear_mask[i] = 1'b1;
                    own_v[i] = 1'b0;
                end
            release_loop(s);
            r.action = vca_pkg::ACT_CLEAR;
        end else if (!clip_loaded[s]) begin
        end else if (op == vca_pkg::OP_LOOP) begin
            if (!looping[s]) begin
                c = pin_v[s] ? int'(pin_ch[s]) : pick_channel(playing);
                if (c >= 0) begin
                    start_on(c, s);
                    pin_v[s] = 1'b1;
                    pin_ch[s] = vca_pkg::CH_W'(c);
                    looping[s] = 1'b1;
                    lrate_v[s] = 1'b1;
                    lrate[s] = rate;
                    r.action = vca_pkg::ACT_START;
                    r.channel = vca_pkg::CH_W'(c);
                    r.start_rate = rate;
                    r.start_looping = 1'b1;
                end
            end else if (rate != 0 && (!lrate_v[s] || lrate[s] != rate) && pin_v[s]) begin
                lrate_v[s] = 1'b1;
                lrate[s] = rate;
                r.action = vca_pkg::ACT_UPDATE;
                r.channel = pin_ch[s];
                r.start_rate = rate;
            end
        end else begin
            if (looping[s] && pin_v[s]) begin
                r.clear_mask[pin_ch[s]] = 1'b1;
                own_v[pin_ch[s]] = 1'b0;
            end
            release_loop(s);
            if (s == vca_pkg::FIXED_RATE_SLOT)
                rate = vca_pkg::FIXED_RATE;
            c = pick_channel(playing);
            if (c >= 0) begin
                start_on(c, s);
                r.action = vca_pkg::ACT_START;
                r.channel = vca_pkg::CH_W'(c);
                r.start_rate = rate;
            end else if (r.clear_mask != 0) begin
                r.action = vca_pkg::ACT_CLEAR;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (alloc_q.size() == 0) begin
                $error("unexpected result tuser=%0d tdata=%h", o_m_tuser, o_m_tdata);
                errors++;
            end else begin
                exp_r = alloc_q.pop_front();
                if (o_m_tuser != exp_r.action) begin
                    $error("action exp %0d got %0d", exp_r.action, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata[4:0] != exp_r.channel) begin
                    $error("channel exp %0d got %0d", exp_r.channel, o_m_tdata[4:0]);
                    errors++;
                end
                if (o_m_tdata[21:5] != exp_r.start_rate) begin
                    $error("start_rate exp %0d got %0d", exp_r.start_rate, o_m_tdata[21:5]);
                    errors++;
                end
                if (o_m_tdata[22] != exp_r.start_looping) begin
                    $error("start_looping exp %0d got %0d", exp_r.start_looping,
                           o_m_tdata[22]);
                    errors++;
                end
                if (o_m_tdata[44:23] != exp_r.clear_mask) begin
                    $error("clear_mask exp %h got %h", exp_r.clear_mask, o_m_tdata[44:23]);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(vca_pkg::t_op op, int s, logic [vca_pkg::RATE_W-1:0] rate,
                            logic [21:0] playing);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {3'b0, playing, rate, 6'(s)};
        do @(posedge i_clk); while (!o_s_tready);
        alloc_q.push_back(predict_alloc(op, s, rate, playing));
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [vca_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == vca_pkg::REG_ENABLE)
            blk_enable = data[0];
        else if (idx == vca_pkg::REG_LOADED)
            clip_loaded = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (alloc_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic test_disabled;
        send_req(vca_pkg::OP_ONESHOT, 0, '1, '1);
        send_req(vca_pkg::OP_LOOP, 63, 17'd1000, '0);
        send_req(vca_pkg::OP_STOP, 5, '0, '0);
        send_req(vca_pkg::OP_STOP_ALL, 0, '0, '0);
        drain();
    endtask

    task automatic test_loops_and_fixed_rate;
        write_reg(vca_pkg::REG_ENABLE, 64'd1);
        write_reg(vca_pkg::REG_LOADED, '1);
        send_req(vca_pkg::OP_ONESHOT, 0, '1, '1);
        send_req(vca_pkg::OP_LOOP, 5, 17'd44100, '1);
        send_req(vca_pkg::OP_LOOP, 5, 17'd44100, '0);
        send_req(vca_pkg::OP_LOOP, 5, '0, '0);
        send_req(vca_pkg::OP_LOOP, 5, 17'd11025, '0);
        send_req(vca_pkg::OP_ONESHOT, 5, 17'd8000, '1);
        send_req(vca_pkg::OP_ONESHOT, 13, 17'd100, '0);
        send_req(vca_pkg::OP_STOP, 13, '0, '0);
        send_req(vca_pkg::OP_STOP, 40, '0, '0);
        send_req(vca_pkg::OP_STOP_ALL, 0, '0, '1);
        drain();
    endtask

    task automatic test_channels_full;
        for (int s = 0; s < vca_pkg::NUM_CHANNELS; s++)
            send_req(vca_pkg::OP_LOOP, s + 20, 17'(s + 1), '1);
        send_req(vca_pkg::OP_LOOP, 60, 17'd500, '1);
        send_req(vca_pkg::OP_ONESHOT, 61, 17'd500, '1);
        send_req(vca_pkg::OP_ONESHOT, 21, 17'd500, '1);
        drain();
    endtask

    task automatic test_not_loaded;
        write_reg(vca_pkg::REG_LOADED, '0);
        send_req(vca_pkg::OP_ONESHOT, 2, 17'd300, '0);
        send_req(vca_pkg::OP_LOOP, 3, 17'd300, '0);
        send_req(vca_pkg::OP_STOP, 25, '0, '0);
        drain();
    endtask

    task automatic test_random(int n);
        int s;
        vca_pkg::t_op op;
        logic [21:0] playing;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0:                op = vca_pkg::OP_STOP_ALL;
                1, 2, 3:          op = vca_pkg::OP_STOP;
                4, 5, 6, 7, 8, 9: op = vca_pkg::OP_LOOP;
                default:          op = vca_pkg::OP_ONESHOT;
            endcase
            s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
            playing = ($urandom_range(2) == 0) ? '1 : 22'($urandom);
            send_req(op, s, ($urandom_range(4) == 0) ? 17'd0 : 17'($urandom), playing);
        end
        drain();
    endtask

    initial begin
        errors = 0;
        send_idle_pct = 22;
        recv_idle_pct = 62;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        blk_enable = 1'b0;
        clip_loaded = '0;
        serial_cnt = '0;
        for (int i = 0; i < vca_pkg::NUM_CHANNELS; i++) begin
            own_v[i] = 1'b0;
            own_slot[i] = '0;
            serial[i] = '0;
        end
        for (int i = 0; i < vca_pkg::NUM_SLOTS; i++) begin
            release_loop(i);
            pin_ch[i] = '0;
            lrate[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_disabled();
        test_loops_and_fixed_rate();
        test_channels_full();
        test_not_loaded();

        write_reg(vca_pkg::REG_LOADED, {$urandom, $urandom} | 64'hFFFF);
        test_random(170);
        send_idle_pct = 62;
        recv_idle_pct = 22;
        write_reg(vca_pkg::REG_LOADED, '1);
        test_random(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(vca_pkg::REG_LOADED, {$urandom, $urandom});
        test_random(80);
        write_reg(vca_pkg::REG_ENABLE, 64'd0);
        test_random(10);
        write_reg(vca_pkg::REG_ENABLE, 64'd1);
        write_reg(vca_pkg::REG_LOADED, '1);
        test_random(80);

        if (errors == 0)
            $display("PASS voice_channel_allocator_top");
        else
            $display("FAIL voice_channel_allocator_top");
        $finish;
    end
endmodule
